FILE: design/cctte_pkg.sv
// ----------------------------------------------------------------------------
// Coulomb counter time-to-empty package
// Widths, constants, codes and shared types of the battery gauge.
// ----------------------------------------------------------------------------
package cctte_pkg;

  // Charge accumulator width; the total saturates one bit short of it
  localparam int ACC_W    = 48;

  // Field widths
  localparam int CUR_W    = 20;
  localparam int STAMP_W  = 27;
  localparam int PCT_W    = 7;
  localparam int CAP_W    = 20;
  localparam int USED_W   = 48;
  localparam int HRS_W    = 5;
  localparam int MIN_W    = 6;
  localparam int SEC_W    = 6;
  localparam int MS_W     = 10;
  localparam int STAT_W   = 2;

  // Configuration port
  localparam int APB_AW   = 3;
  localparam int APB_DW   = 32;

  // Derived datapath widths
  localparam int SCALE_W  = 16;
  localparam int HOUR_W   = 22;
  localparam int CAP_MS_W = CAP_W + HOUR_W;
  localparam int PC_W     = PCT_W + CAP_W;
  localparam int PRE_W    = PC_W + SCALE_W;
  localparam int PRE_CMP_W = (PRE_W > ACC_W) ? PRE_W : ACC_W;
  localparam int PROD_W   = CUR_W + STAMP_W + 2;
  localparam int SUM_W    = ((ACC_W > PROD_W) ? ACC_W : PROD_W) + 1;
  localparam int WIDE_W   = (ACC_W > CAP_MS_W) ? ACC_W : CAP_MS_W;
  localparam int NUM_W    = WIDE_W + 1;
  localparam int DIFF_W   = WIDE_W + 2;
  localparam int DAY_W    = 27;
  localparam int DIG_W    = HRS_W + MIN_W + SEC_W;
  localparam int DIV_STEPS   = NUM_W;
  localparam int SPLIT_STEPS = DIG_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam int SPLIT_W  = $clog2(SPLIT_STEPS);

  typedef logic signed [ACC_W-1:0]   acc_t;
  typedef logic        [ACC_W-1:0]   acc_mag_t;
  typedef logic signed [SUM_W-1:0]   sum_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [CUR_W:0]     isum_t;
  typedef logic signed [STAMP_W:0]   dt_t;
  typedef logic signed [CUR_W-1:0]   cur_t;
  typedef logic        [CUR_W-1:0]   mag_t;
  typedef logic        [STAMP_W-1:0] stamp_t;
  typedef logic        [PCT_W-1:0]   pct_t;
  typedef logic        [CAP_W-1:0]   cap_t;
  typedef logic        [CAP_MS_W-1:0] cap_ms_t;
  typedef logic        [PC_W-1:0]    pc_t;
  typedef logic        [PRE_W-1:0]   pre_t;
  typedef logic        [PRE_CMP_W-1:0] pre_cmp_t;
  typedef logic        [WIDE_W-1:0]  wide_t;
  typedef logic        [NUM_W-1:0]   num_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;
  typedef logic        [DAY_W-1:0]   day_t;
  typedef logic        [DIG_W-1:0]   dig_t;
  typedef logic        [CNT_W-1:0]   cnt_t;
  typedef logic        [SPLIT_W-1:0] split_idx_t;
  typedef logic signed [USED_W-1:0]  used_t;
  typedef logic        [STAT_W-1:0]  stat_t;
  typedef logic        [APB_AW-1:0]  apb_addr_t;
  typedef logic        [APB_DW-1:0]  apb_data_t;

  // Reset values and scale constants
  localparam pct_t   PCT_RESET    = 7'd100;
  localparam cap_t   CAP_RESET    = 20'd123000;
  localparam logic [SCALE_W-1:0] PRESET_SCALE = 16'd36000;
  localparam logic [HOUR_W-1:0]  MS_PER_HOUR  = 22'd3600000;
  localparam logic [15:0]        MS_PER_MIN   = 16'd60000;
  localparam logic [9:0]         MS_PER_SEC   = 10'd1000;
  localparam day_t   MS_PER_DAY   = 27'd86400000;
  localparam acc_t   TOTAL_RESET  = acc_t'(64'd100 * 64'd123000 * 64'd36000);
  localparam acc_t   ACC_MAX      = {1'b0, {(ACC_W-1){1'b1}}};
  localparam sum_t   SUM_MAX      = sum_t'(acc_mag_t'(ACC_MAX));
  localparam sum_t   SUM_MIN      = -SUM_MAX;

  // Result status codes
  localparam stat_t ST_OK       = 2'd0;
  localparam stat_t ST_ZERO_CUR = 2'd1;
  localparam stat_t ST_NEG_TIME = 2'd2;

  // Register index, taken from paddr[2]
  typedef enum logic {
    REG_PERCENT  = 1'b0,
    REG_CAPACITY = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    GS_IDLE,
    GS_MUL,
    GS_ACC,
    GS_NUM,
    GS_WAIT,
    GS_DONE
  } gauge_state_t;

  typedef enum logic [1:0] {
    DV_IDLE,
    DV_DIV,
    DV_SPLIT
  } div_state_t;

  // Request to the serial divider
  typedef struct packed {
    logic start;
    logic zero;
    num_t num;
    mag_t divisor;
  } div_req_t;

  // Time left, split into fields
  typedef struct packed {
    logic             done;
    logic [HRS_W-1:0] hours;
    logic [MIN_W-1:0] minutes;
    logic [SEC_W-1:0] seconds;
    logic [MS_W-1:0]  millis;
  } div_rsp_t;

  // Shifted unit for each step of the time split, most significant digit first
  function automatic day_t split_divisor(input split_idx_t step);
    day_t d;
    case (step)
      5'd0:    d = day_t'(MS_PER_HOUR) << 4;
      5'd1:    d = day_t'(MS_PER_HOUR) << 3;
      5'd2:    d = day_t'(MS_PER_HOUR) << 2;
      5'd3:    d = day_t'(MS_PER_HOUR) << 1;
      5'd4:    d = day_t'(MS_PER_HOUR);
      5'd5:    d = day_t'(MS_PER_MIN) << 5;
      5'd6:    d = day_t'(MS_PER_MIN) << 4;
      5'd7:    d = day_t'(MS_PER_MIN) << 3;
      5'd8:    d = day_t'(MS_PER_MIN) << 2;
      5'd9:    d = day_t'(MS_PER_MIN) << 1;
      5'd10:   d = day_t'(MS_PER_MIN);
      5'd11:   d = day_t'(MS_PER_SEC) << 5;
      5'd12:   d = day_t'(MS_PER_SEC) << 4;
      5'd13:   d = day_t'(MS_PER_SEC) << 3;
      5'd14:   d = day_t'(MS_PER_SEC) << 2;
      5'd15:   d = day_t'(MS_PER_SEC) << 1;
      5'd16:   d = day_t'(MS_PER_SEC);
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

FILE: design/cctte_ifs.sv
// ----------------------------------------------------------------------------
// Coulomb counter channel interfaces
// Valid/ready channels for current samples and gauge results.
// ----------------------------------------------------------------------------
interface cctte_meas_if;
  logic                  valid;
  logic                  ready;
  cctte_pkg::cur_t       current_ma;
  cctte_pkg::stamp_t     timestamp_ms;

  modport source (output valid, output current_ma, output timestamp_ms, input ready);
  modport sink   (input valid, input current_ma, input timestamp_ms, output ready);
endinterface

interface cctte_gauge_if;
  logic                              valid;
  logic                              ready;
  cctte_pkg::used_t                  used_charge;
  logic                              charging;
  logic [cctte_pkg::HRS_W-1:0]       hours_left;
  logic [cctte_pkg::MIN_W-1:0]       minutes_left;
  logic [cctte_pkg::SEC_W-1:0]       seconds_left;
  logic [cctte_pkg::MS_W-1:0]        millis_left;
  cctte_pkg::stat_t                  status;

  modport source (output valid, output used_charge, output charging, output hours_left,
                  output minutes_left, output seconds_left, output millis_left,
                  output status, input ready);
  modport sink   (input valid, input used_charge, input charging, input hours_left,
                  input minutes_left, input seconds_left, input millis_left,
                  input status, output ready);
endinterface

FILE: design/cctte_divsplit.sv
// ----------------------------------------------------------------------------
// Bit-serial divider and time split
// Restoring division one quotient bit a cycle, folding each bit into a
// modulo-one-day remainder, then a 17-step split into h/m/s/ms.
// ----------------------------------------------------------------------------
module cctte_divsplit (
  input  logic                clk,
  input  logic                rst,
  input  cctte_pkg::div_req_t req,
  output cctte_pkg::div_rsp_t rsp
);

  cctte_pkg::div_state_t state;
  cctte_pkg::div_state_t state_next;

  cctte_pkg::num_t   num;
  cctte_pkg::mag_t   divisor;
  cctte_pkg::mag_t   rem;
  cctte_pkg::day_t   day_rem;
  cctte_pkg::dig_t   dig;
  cctte_pkg::cnt_t   cnt;
  logic              done;

  cctte_pkg::mag_t   rem_sh;
  cctte_pkg::mag_t   rem_new;
  logic              q_bit;
  logic [cctte_pkg::DAY_W:0] day_sh;
  cctte_pkg::day_t   day_div;
  cctte_pkg::day_t   sp_div;
  cctte_pkg::day_t   day_split;
  logic              sp_bit;
  logic              last_div;
  logic              last_split;

  // Division step: shift in the next numerator bit, trial subtract
  assign rem_sh  = {rem[cctte_pkg::CUR_W-2:0], num[cctte_pkg::NUM_W-1]};
  assign q_bit   = rem_sh >= divisor;
  assign rem_new = q_bit ? cctte_pkg::mag_t'(rem_sh - divisor) : rem_sh;

  // Fold the quotient bit into the remainder modulo one day
  assign day_sh  = {day_rem, q_bit};
  assign day_div = (day_sh >= {1'b0, cctte_pkg::MS_PER_DAY}) ?
                   cctte_pkg::day_t'(day_sh - {1'b0, cctte_pkg::MS_PER_DAY}) :
                   day_sh[cctte_pkg::DAY_W-1:0];

  // Split step: one digit bit against the shifted unit
  assign sp_div    = cctte_pkg::split_divisor(cnt[cctte_pkg::SPLIT_W-1:0]);
  assign sp_bit    = day_rem >= sp_div;
  assign day_split = sp_bit ? cctte_pkg::day_t'(day_rem - sp_div) : day_rem;

  assign last_div   = cnt == cctte_pkg::cnt_t'(cctte_pkg::DIV_STEPS - 1);
  assign last_split = cnt == cctte_pkg::cnt_t'(cctte_pkg::SPLIT_STEPS - 1);

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cctte_pkg::DV_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= (state == cctte_pkg::DV_SPLIT) && last_split;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      cctte_pkg::DV_IDLE: begin
        if (req.start) begin
          state_next = req.zero ? cctte_pkg::DV_SPLIT : cctte_pkg::DV_DIV;
        end
      end
      cctte_pkg::DV_DIV: begin
        if (last_div) begin
          state_next = cctte_pkg::DV_SPLIT;
        end
      end
      cctte_pkg::DV_SPLIT: begin
        if (last_split) begin
          state_next = cctte_pkg::DV_IDLE;
        end
      end
      default: state_next = cctte_pkg::DV_IDLE;
    endcase
  end

  // Datapath: load, divide, split; hold while idle
  always_ff @(posedge clk) begin
    unique case (state)
      cctte_pkg::DV_IDLE: begin
        if (req.start) begin
          num     <= req.num;
          divisor <= req.divisor;
          rem     <= '0;
          day_rem <= '0;
          dig     <= '0;
          cnt     <= '0;
        end
      end
      cctte_pkg::DV_DIV: begin
        num     <= num << 1;
        rem     <= rem_new;
        day_rem <= day_div;
        cnt     <= last_div ? '0 : cctte_pkg::cnt_t'(cnt + 1'b1);
      end
      cctte_pkg::DV_SPLIT: begin
        day_rem <= day_split;
        dig     <= {dig[cctte_pkg::DIG_W-2:0], sp_bit};
        cnt     <= cctte_pkg::cnt_t'(cnt + 1'b1);
      end
      default: ;
    endcase
  end

  assign rsp.done    = done;
  assign rsp.hours   = dig[cctte_pkg::DIG_W-1 -: cctte_pkg::HRS_W];
  assign rsp.minutes = dig[cctte_pkg::SEC_W+cctte_pkg::MIN_W-1 -: cctte_pkg::MIN_W];
  assign rsp.seconds = dig[cctte_pkg::SEC_W-1:0];
  assign rsp.millis  = day_rem[cctte_pkg::MS_W-1:0];

endmodule

FILE: design/coulomb_counter_time_to_empty_unit.sv
// ----------------------------------------------------------------------------
// Coulomb counter with time-to-empty readout
// Integrates current samples into a saturating charge total and reports the
// time until empty (or full, while charging) as h/m/s/ms.
// ----------------------------------------------------------------------------
// Each request passes the 49-step bit-serial divider and then the 17-step
//   time split; the divider is skipped when the time left is forced to zero
//   (zero current or capacity exhausted). A new request is taken only once
//   the previous result has been loaded into the output register.
// Reset (rst, synchronous): 100 percent, 123000 mAh, total preset to match,
//   no previous sample. A write of initial_percent presets the total through
//   preset_s1, preset_s2 and preset_s3, during which no request is taken.
module coulomb_counter_time_to_empty_unit (
  input  logic                  clk,
  input  logic                  rst,
  cctte_meas_if.sink            meas,
  cctte_gauge_if.source         gauge,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  cctte_pkg::apb_addr_t  paddr,
  input  cctte_pkg::apb_data_t  pwdata,
  output cctte_pkg::apb_data_t  prdata,
  output logic                  pready
);

  cctte_pkg::gauge_state_t state;
  cctte_pkg::gauge_state_t state_next;

  // Configuration and preset pipe
  cctte_pkg::pct_t     percent;
  cctte_pkg::cap_t     capacity;
  cctte_pkg::cap_ms_t  cap_ms;
  cctte_pkg::pc_t      pre_pc;
  cctte_pkg::pre_t     pre_val;
  cctte_pkg::acc_t     pre_clamped;
  logic                preset_s1;
  logic                preset_s2;
  logic                preset_s3;
  logic                pre_busy;
  logic                cfg_wr;
  cctte_pkg::reg_idx_t reg_idx;

  // Sample and integration state
  cctte_pkg::cur_t     cur;
  cctte_pkg::stamp_t   stamp;
  cctte_pkg::cur_t     last_current;
  cctte_pkg::stamp_t   last_stamp;
  logic                have_last;
  cctte_pkg::prod_t    prod;
  cctte_pkg::prod_t    prod_next;
  cctte_pkg::isum_t    isum;
  cctte_pkg::dt_t      dt;
  cctte_pkg::acc_t     charge_total;
  cctte_pkg::prod_t    half;
  cctte_pkg::sum_t     acc_sum;
  cctte_pkg::acc_t     acc_clamped;

  // Numerator selection
  cctte_pkg::acc_mag_t abs_total;
  cctte_pkg::diff_t    diff;
  logic                cur_zero;
  logic                cur_neg;
  logic                cap_short;
  cctte_pkg::stat_t    status;
  cctte_pkg::stat_t    status_next;

  cctte_pkg::div_req_t div_req;
  cctte_pkg::div_rsp_t div_rsp;

  // Handshake and output register
  logic                in_ready;
  logic                div_start;
  logic                out_load;
  logic                out_valid;
  cctte_pkg::used_t    out_used;
  logic                out_charging;
  cctte_pkg::div_rsp_t out_time;
  cctte_pkg::stat_t    out_status;

  // Configuration port
  assign cfg_wr  = psel && penable && pwrite;
  assign reg_idx = cctte_pkg::reg_idx_t'(paddr[2]);
  assign pready  = 1'b1;

  always_comb begin
    unique case (reg_idx)
      cctte_pkg::REG_PERCENT:  prdata = cctte_pkg::apb_data_t'(percent);
      cctte_pkg::REG_CAPACITY: prdata = cctte_pkg::apb_data_t'(capacity);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      percent   <= cctte_pkg::PCT_RESET;
      capacity  <= cctte_pkg::CAP_RESET;
      preset_s1 <= 1'b0;
      preset_s2 <= 1'b0;
      preset_s3 <= 1'b0;
    end else begin
      preset_s1 <= cfg_wr && (reg_idx == cctte_pkg::REG_PERCENT);
      preset_s2 <= preset_s1;
      preset_s3 <= preset_s2;
      if (cfg_wr) begin
        unique case (reg_idx)
          cctte_pkg::REG_PERCENT:  percent  <= pwdata[cctte_pkg::PCT_W-1:0];
          cctte_pkg::REG_CAPACITY: capacity <= pwdata[cctte_pkg::CAP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  assign pre_busy = preset_s1 || preset_s2 || preset_s3;

  // Free-running products: preset total and capacity in mA-ms
  always_ff @(posedge clk) begin
    pre_pc  <= cctte_pkg::pc_t'(percent) * cctte_pkg::pc_t'(capacity);
    pre_val <= cctte_pkg::pre_t'(pre_pc) * cctte_pkg::pre_t'(cctte_pkg::PRESET_SCALE);
    cap_ms  <= cctte_pkg::cap_ms_t'(capacity) * cctte_pkg::cap_ms_t'(cctte_pkg::MS_PER_HOUR);
  end

  assign pre_clamped =
    (cctte_pkg::pre_cmp_t'(pre_val) > cctte_pkg::pre_cmp_t'(cctte_pkg::acc_mag_t'(cctte_pkg::ACC_MAX)))
    ? cctte_pkg::ACC_MAX : cctte_pkg::acc_t'(pre_val);

  // Trapezoid product
  assign isum      = cctte_pkg::isum_t'(cur) + cctte_pkg::isum_t'(last_current);
  assign dt        = $signed({1'b0, stamp}) - $signed({1'b0, last_stamp});
  assign prod_next = cctte_pkg::prod_t'(isum) * cctte_pkg::prod_t'(dt);

  // Halve toward minus infinity and add with saturation
  assign half    = prod >>> 1;
  assign acc_sum = cctte_pkg::sum_t'(charge_total) + cctte_pkg::sum_t'(half);

  always_comb begin
    if (acc_sum > cctte_pkg::SUM_MAX) begin
      acc_clamped = cctte_pkg::ACC_MAX;
    end else if (acc_sum < cctte_pkg::SUM_MIN) begin
      acc_clamped = -cctte_pkg::ACC_MAX;
    end else begin
      acc_clamped = cctte_pkg::acc_t'(acc_sum);
    end
  end

  // Numerator and status for the time left
  assign cur_zero  = cur == '0;
  assign cur_neg   = cur[cctte_pkg::CUR_W-1];
  assign abs_total = charge_total[cctte_pkg::ACC_W-1] ?
                     cctte_pkg::acc_mag_t'(-charge_total) : cctte_pkg::acc_mag_t'(charge_total);
  assign diff      = $signed({2'b00, cctte_pkg::wide_t'(cap_ms)}) -
                     cctte_pkg::diff_t'(charge_total);
  assign cap_short = diff[cctte_pkg::DIFF_W-1];

  always_comb begin
    if (cur_zero) begin
      status_next = cctte_pkg::ST_ZERO_CUR;
    end else if (!cur_neg && cap_short) begin
      status_next = cctte_pkg::ST_NEG_TIME;
    end else begin
      status_next = cctte_pkg::ST_OK;
    end
  end

  assign div_req.start   = div_start;
  assign div_req.zero    = status_next != cctte_pkg::ST_OK;
  assign div_req.num     = cur_neg ? cctte_pkg::num_t'(abs_total) :
                                     diff[cctte_pkg::NUM_W-1:0];
  assign div_req.divisor = cur_neg ? cctte_pkg::mag_t'(-cur) : cctte_pkg::mag_t'(cur);

  cctte_divsplit u_divsplit (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cctte_pkg::GS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      cctte_pkg::GS_IDLE: begin
        in_ready = !pre_busy;
        if (meas.valid && !pre_busy) begin
          state_next = cctte_pkg::GS_MUL;
        end
      end
      cctte_pkg::GS_MUL: state_next = cctte_pkg::GS_ACC;
      cctte_pkg::GS_ACC: state_next = cctte_pkg::GS_NUM;
      cctte_pkg::GS_NUM: begin
        div_start  = 1'b1;
        state_next = cctte_pkg::GS_WAIT;
      end
      cctte_pkg::GS_WAIT: begin
        if (div_rsp.done) begin
          state_next = cctte_pkg::GS_DONE;
        end
      end
      cctte_pkg::GS_DONE: begin
        out_load = !out_valid || gauge.ready;
        if (out_load) begin
          state_next = cctte_pkg::GS_IDLE;
        end
      end
      default: state_next = cctte_pkg::GS_IDLE;
    endcase
  end

  assign meas.ready = in_ready;

  // Capture the request, then the trapezoid product and the status
  always_ff @(posedge clk) begin
    if (meas.valid && in_ready) begin
      cur   <= meas.current_ma;
      stamp <= meas.timestamp_ms;
    end
    if (state == cctte_pkg::GS_MUL) begin
      prod <= have_last ? prod_next : '0;
    end
    if (state == cctte_pkg::GS_NUM) begin
      status <= status_next;
    end
  end

  // Integration state
  always_ff @(posedge clk) begin
    if (rst) begin
      charge_total <= cctte_pkg::TOTAL_RESET;
      last_current <= '0;
      last_stamp   <= '0;
      have_last    <= 1'b0;
    end else begin
      if (preset_s3) begin
        charge_total <= pre_clamped;
      end else if (state == cctte_pkg::GS_ACC) begin
        charge_total <= acc_clamped;
      end
      if (state == cctte_pkg::GS_MUL) begin
        last_current <= cur;
        last_stamp   <= stamp;
        have_last    <= 1'b1;
      end
    end
  end

  // Output register: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (gauge.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_used     <= cctte_pkg::used_t'(charge_total);
      out_charging <= cur_neg;
      out_time     <= div_rsp;
      out_status   <= status;
    end
  end

  assign gauge.valid        = out_valid;
  assign gauge.used_charge  = out_used;
  assign gauge.charging     = out_charging;
  assign gauge.hours_left   = out_time.hours;
  assign gauge.minutes_left = out_time.minutes;
  assign gauge.seconds_left = out_time.seconds;
  assign gauge.millis_left  = out_time.millis;
  assign gauge.status       = out_status;

endmodule

FILE: design/cctte_chk.sv
// ----------------------------------------------------------------------------
// Coulomb counter port checker
// Port-level properties of the gauge, bound to the top level.
// ----------------------------------------------------------------------------
module cctte_chk (
  input logic                         clk,
  input logic                         rst,
  input logic                         meas_valid,
  input logic                         meas_ready,
  input logic                         gauge_valid,
  input logic                         gauge_ready,
  input cctte_pkg::used_t             used_charge,
  input logic                         charging,
  input logic [cctte_pkg::HRS_W-1:0]  hours_left,
  input logic [cctte_pkg::MIN_W-1:0]  minutes_left,
  input logic [cctte_pkg::SEC_W-1:0]  seconds_left,
  input logic [cctte_pkg::MS_W-1:0]   millis_left,
  input cctte_pkg::stat_t             status
);

  // One request at a time: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    meas_valid && meas_ready |=> !meas_ready)
    else $error("request accepted while previous one still in flight");

  // Stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    gauge_valid && !gauge_ready |=> gauge_valid && $stable(used_charge) && $stable(status))
    else $error("stalled result changed");

  // Forced-zero status gives zero time and never charging
  a_zero_time: assert property (@(posedge clk) disable iff (rst)
    gauge_valid && (status != cctte_pkg::ST_OK) |->
      hours_left == '0 && minutes_left == '0 && seconds_left == '0 &&
      millis_left == '0 && !charging)
    else $error("time fields not zero for a forced-zero status");

  // Split fields stay within a day
  a_time_range: assert property (@(posedge clk) disable iff (rst)
    gauge_valid |-> hours_left < 5'd24 && minutes_left < 6'd60 &&
                    seconds_left < 6'd60 && millis_left < 10'd1000 &&
                    status != 2'd3)
    else $error("time split out of range");

endmodule

bind coulomb_counter_time_to_empty_unit cctte_chk u_cctte_chk (
  .clk          (clk),
  .rst          (rst),
  .meas_valid   (meas.valid),
  .meas_ready   (meas.ready),
  .gauge_valid  (gauge.valid),
  .gauge_ready  (gauge.ready),
  .used_charge  (gauge.used_charge),
  .charging     (gauge.charging),
  .hours_left   (gauge.hours_left),
  .minutes_left (gauge.minutes_left),
  .seconds_left (gauge.seconds_left),
  .millis_left  (gauge.millis_left),
  .status       (gauge.status)
);

FILE: verif/coulomb_counter_time_to_empty_unit_tb.sv
// ----------------------------------------------------------------------------
// Coulomb counter time-to-empty testbench
// Drives current samples through the valid/ready channels and checks every
// gauge result against an in-bench predictor of the charge total and the time
// left. Directed samples are followed by random phases under several register
// settings. Random idling runs on both channels, with long output hold-offs.
// ----------------------------------------------------------------------------
module coulomb_counter_time_to_empty_unit_tb;

  // Predictor constants
  localparam longint USED_LIM   = (64'sd1 <<< 47) - 1;
  localparam longint PRESET_MUL = 36000;
  localparam longint HOUR_MSEC  = 3600000;
  localparam longint MIN_MSEC   = 60000;
  localparam longint SEC_MSEC   = 1000;
  localparam longint DAY_MSEC   = 86400000;
  localparam int     RESET_PCT  = 100;
  localparam int     RESET_CAP  = 123000;

  // Stimulus constants
  localparam int CUR_TOP     = 524287;
  localparam int CUR_BOTTOM  = -524288;
  localparam int STAMP_TOP   = 134217727;
  localparam int DAY_LAST    = 86399999;
  localparam int HOLD_CYCLES = 400;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    cctte_pkg::cur_t   current;
    cctte_pkg::stamp_t stamp;
  } sample_t;

  typedef struct packed {
    cctte_pkg::used_t            used;
    logic                        charging;
    logic [cctte_pkg::HRS_W-1:0] hours;
    logic [cctte_pkg::MIN_W-1:0] minutes;
    logic [cctte_pkg::SEC_W-1:0] seconds;
    logic [cctte_pkg::MS_W-1:0]  millis;
    cctte_pkg::stat_t            status;
  } gauge_rec_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  cctte_pkg::apb_addr_t paddr;
  cctte_pkg::apb_data_t pwdata;
  cctte_pkg::apb_data_t prdata;
  logic                 pready;

  cctte_meas_if  meas_ch ();
  cctte_gauge_if gauge_ch ();

  coulomb_counter_time_to_empty_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .meas    (meas_ch),
    .gauge   (gauge_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor state
  cctte_pkg::pct_t soc_pct;
  cctte_pkg::cap_t cap_mah;
  longint          used_total;
  longint          prev_cur;
  longint          prev_stamp;
  bit              have_prev;

  sample_t    sample_q[$];
  gauge_rec_t gauge_due_q[$];
  longint     walk_stamp;
  bit         calm;
  bit         meas_taken;
  int         mismatches;
  int         results_seen;
  int         hold_at;
  int unsigned hold_left;
  int unsigned send_gap;
  int unsigned ready_gap;

  // Clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Load the charge total from the state of charge and the capacity
  function automatic void preset_used();
    longint unsigned v;
    v = longint'(soc_pct) * longint'(cap_mah) * PRESET_MUL;
    used_total = (v > USED_LIM) ? USED_LIM : longint'(v);
  endfunction

  function automatic longint sat_add_used(longint a, longint d);
    if (d > 0 && a > USED_LIM - d) return USED_LIM;
    if (d < 0 && a < -USED_LIM - d) return -USED_LIM;
    return a + d;
  endfunction

  // Integrate one sample and work out the time left
  function automatic gauge_rec_t predict_gauge(cctte_pkg::cur_t cur, cctte_pkg::stamp_t stamp);
    gauge_rec_t r;
    longint     i_now;
    longint     dt;
    longint     prod;
    longint     cap_ms;
    longint     mag;
    longint     t_ms;
    i_now = longint'(cur);
    if (have_prev) begin
      dt = longint'(stamp) - prev_stamp;
      prod = (i_now + prev_cur) * dt;
      // floor halving of the trapezoid
      used_total = sat_add_used(used_total, prod >>> 1);
    end
    prev_cur = i_now;
    prev_stamp = longint'(stamp);
    have_prev = 1'b1;

    t_ms = 0;
    r.status = cctte_pkg::ST_OK;
    if (i_now == 0) begin
      r.status = cctte_pkg::ST_ZERO_CUR;
    end else if (i_now < 0) begin
      mag = (used_total < 0) ? -used_total : used_total;
      t_ms = mag / (-i_now);
    end else begin
      cap_ms = longint'(cap_mah) * HOUR_MSEC;
      if (used_total > cap_ms) begin
        r.status = cctte_pkg::ST_NEG_TIME;
      end else begin
        t_ms = (cap_ms - used_total) / i_now;
      end
    end
    t_ms = t_ms % DAY_MSEC;

    r.used     = cctte_pkg::used_t'(used_total);
    r.charging = (i_now < 0);
    r.hours    = (cctte_pkg::HRS_W)'(t_ms / HOUR_MSEC);
    t_ms       = t_ms % HOUR_MSEC;
    r.minutes  = (cctte_pkg::MIN_W)'(t_ms / MIN_MSEC);
    t_ms       = t_ms % MIN_MSEC;
    r.seconds  = (cctte_pkg::SEC_W)'(t_ms / SEC_MSEC);
    r.millis   = (cctte_pkg::MS_W)'(t_ms % SEC_MSEC);
    return r;
  endfunction

  // Idle length: mostly none or short, a few long
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (calm || roll < 60) return 0;
    if (roll < 90) return $urandom_range(4, 1);
    if (roll < 97) return $urandom_range(30, 5);
    return $urandom_range(150, 60);
  endfunction

  // Random sample: a time-ordered walk, or raw noise for noise_pct percent
  function automatic sample_t make_sample(int unsigned noise_pct);
    sample_t     s;
    int unsigned roll;
    int unsigned step;
    int unsigned mag;
    roll = $urandom_range(99);
    if (roll < noise_pct) begin
      s.current = cctte_pkg::cur_t'($urandom);
      s.stamp   = cctte_pkg::stamp_t'($urandom);
      return s;
    end
    roll = $urandom_range(99);
    if (roll < 3) step = 0;
    else if (roll < 85) step = $urandom_range(2000, 1);
    else if (roll < 97) step = $urandom_range(60000, 2001);
    else step = $urandom_range(3600000, 60001);
    walk_stamp = walk_stamp + step;
    // roll over midnight
    if (walk_stamp >= DAY_MSEC) walk_stamp = walk_stamp - DAY_MSEC;
    roll = $urandom_range(99);
    if (roll < 10) mag = 0;
    else if (roll < 70) mag = $urandom_range(3000, 1);
    else if (roll < 95) mag = $urandom_range(100000, 3001);
    else mag = $urandom_range(500000, 100001);
    s.current = $urandom_range(1) ? -cctte_pkg::cur_t'(mag) : cctte_pkg::cur_t'(mag);
    s.stamp   = cctte_pkg::stamp_t'(walk_stamp);
    return s;
  endfunction

  function automatic void check_field(string name, logic signed [63:0] want,
                                      logic signed [63:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  task automatic queue_sample(int cur, int stamp);
    sample_q.push_back('{current: cctte_pkg::cur_t'(cur), stamp: cctte_pkg::stamp_t'(stamp)});
  endtask

  // Wait until every request is taken and every result has come back
  task automatic wait_idle();
    do @(posedge clk);
    while (sample_q.size() != 0 || meas_ch.valid || gauge_due_q.size() != 0);
  endtask

  // Register write: setup cycle, then access cycle until pready
  task automatic write_reg(cctte_pkg::reg_idx_t idx, int unsigned value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= cctte_pkg::apb_addr_t'({idx, 2'b00});
    pwdata  <= cctte_pkg::apb_data_t'(value);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk);
    while (!pready);
    case (idx)
      cctte_pkg::REG_PERCENT: begin
        soc_pct = cctte_pkg::pct_t'(value);
        preset_used();
      end
      cctte_pkg::REG_CAPACITY: begin
        cap_mah = cctte_pkg::cap_t'(value);
      end
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_random(int n, int unsigned noise_pct);
    @(posedge clk);
    repeat (n) sample_q.push_back(make_sample(noise_pct));
    wait_idle();
  endtask

  // Sample driver: hold an offered request until taken, then idle or advance
  always @(negedge clk) begin : drive_meas
    sample_t s;
    if (rst) begin
      meas_ch.valid <= 1'b0;
    end else if (meas_ch.valid && !meas_taken) begin
      // hold the request
    end else if (send_gap != 0) begin
      meas_ch.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (sample_q.size() != 0) begin
      s = sample_q.pop_front();
      meas_ch.valid        <= 1'b1;
      meas_ch.current_ma   <= s.current;
      meas_ch.timestamp_ms <= s.stamp;
      send_gap <= pick_gap();
    end else begin
      meas_ch.valid <= 1'b0;
    end
  end

  // Result ready: long hold-offs at set marks, otherwise random gaps
  always @(negedge clk) begin
    if (rst) begin
      gauge_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      gauge_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (results_seen >= hold_at) begin
      gauge_ch.ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_at <= hold_at + 700;
    end else if (ready_gap != 0) begin
      gauge_ch.ready <= 1'b0;
      ready_gap <= ready_gap - 1;
    end else begin
      gauge_ch.ready <= 1'b1;
      ready_gap <= pick_gap();
    end
  end

  // Check results, then predict for a newly taken request
  always @(posedge clk) begin : watch_gauge
    gauge_rec_t want;
    meas_taken <= meas_ch.valid && meas_ch.ready;
    if (!rst && gauge_ch.valid && gauge_ch.ready) begin
      results_seen <= results_seen + 1;
      if (gauge_due_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with no request outstanding", $time);
      end else begin
        want = gauge_due_q.pop_front();
        check_field("used_charge", want.used, gauge_ch.used_charge);
        check_field("charging", want.charging, gauge_ch.charging);
        check_field("hours_left", want.hours, gauge_ch.hours_left);
        check_field("minutes_left", want.minutes, gauge_ch.minutes_left);
        check_field("seconds_left", want.seconds, gauge_ch.seconds_left);
        check_field("millis_left", want.millis, gauge_ch.millis_left);
        check_field("status", want.status, gauge_ch.status);
      end
    end
    if (!rst && meas_ch.valid && meas_ch.ready)
      gauge_due_q.push_back(predict_gauge(meas_ch.current_ma, meas_ch.timestamp_ms));
  end

  // Run limit
  initial begin
    #40000000;
    $display("== FAIL ==");
    $finish;
  end

  // Phases
  initial begin
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    meas_ch.valid        = 1'b0;
    meas_ch.current_ma   = '0;
    meas_ch.timestamp_ms = '0;
    gauge_ch.ready       = 1'b0;
    calm         = 1'b0;
    meas_taken   = 1'b0;
    mismatches   = 0;
    results_seen = 0;
    hold_at      = 300;
    hold_left    = 0;
    send_gap     = 0;
    ready_gap    = 0;
    walk_stamp   = 0;
    soc_pct      = cctte_pkg::pct_t'(RESET_PCT);
    cap_mah      = cctte_pkg::cap_t'(RESET_CAP);
    preset_used();
    prev_cur     = 0;
    prev_stamp   = 0;
    have_prev    = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed samples under the reset settings
    queue_sample(1000, 0);              // first sample, nothing integrated
    queue_sample(1000, 1000);           // used beyond capacity
    queue_sample(0, 2000);              // zero current
    queue_sample(-1, 2001);             // odd negative product
    queue_sample(7, 2010);
    queue_sample(-4, 2013);             // odd positive product
    queue_sample(-5, 2014);             // odd negative product
    queue_sample(500000, 1500);         // stamp going backwards
    queue_sample(-500000, DAY_LAST);
    queue_sample(1, DAY_LAST);          // huge time left, wraps the day
    // drive the total up, still short of the positive clamp
    queue_sample(CUR_TOP, 0);
    queue_sample(CUR_TOP, STAMP_TOP);
    queue_sample(CUR_BOTTOM, STAMP_TOP);
    queue_sample(CUR_BOTTOM, 0);
    // and then down into the negative clamp
    queue_sample(CUR_TOP, STAMP_TOP);
    queue_sample(CUR_TOP, 0);
    queue_sample(CUR_BOTTOM, 0);
    queue_sample(CUR_BOTTOM, STAMP_TOP);
    queue_sample(CUR_TOP, STAMP_TOP);
    queue_sample(CUR_TOP, 0);
    queue_sample(CUR_BOTTOM, 0);
    queue_sample(CUR_BOTTOM, STAMP_TOP);
    queue_sample(CUR_TOP, STAMP_TOP);
    queue_sample(-2, 0);
    wait_idle();

    // Exactly one day left wraps to zero hours
    queue_sample(0, 5000);
    wait_idle();
    write_reg(cctte_pkg::REG_PERCENT, 0);
    write_reg(cctte_pkg::REG_CAPACITY, 24);
    queue_sample(1, 5000);
    queue_sample(2, 5000);
    wait_idle();

    // Smallest capacity, empty start
    write_reg(cctte_pkg::REG_CAPACITY, 1);
    write_reg(cctte_pkg::REG_PERCENT, 0);
    run_random(200, 10);

    // Largest field values, no random gaps
    write_reg(cctte_pkg::REG_CAPACITY, 1048575);
    write_reg(cctte_pkg::REG_PERCENT, 127);
    calm = 1'b1;
    run_random(200, 10);
    calm = 1'b0;

    write_reg(cctte_pkg::REG_CAPACITY, 123000);
    write_reg(cctte_pkg::REG_PERCENT, 50);
    run_random(350, 10);

    write_reg(cctte_pkg::REG_CAPACITY, 1000000);
    write_reg(cctte_pkg::REG_PERCENT, 100);
    run_random(200, 10);

    // Preset with the old capacity, then change it
    write_reg(cctte_pkg::REG_PERCENT, $urandom_range(100));
    write_reg(cctte_pkg::REG_CAPACITY, $urandom_range(1000000, 1));
    run_random(300, 10);

    // Mostly noise
    write_reg(cctte_pkg::REG_CAPACITY, 5000);
    write_reg(cctte_pkg::REG_PERCENT, 20);
    run_random(350, 60);

    // Let any stray result show up
    repeat (100) @(posedge clk);
    mismatches = mismatches + gauge_due_q.size();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
